/* design/call_graph_profile_accumulator_defines.svh */
// Assertion helpers shared by the design files.
`ifndef CALL_GRAPH_PROFILE_ACCUMULATOR_DEFINES_SVH
`define CALL_GRAPH_PROFILE_ACCUMULATOR_DEFINES_SVH

`define CGPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CGPA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/cgpa_pkg.sv */
package cgpa_pkg;

  localparam int NUM_BLOCKS_DEF   = 16;
  localparam int CALL_DEPTH_DEF   = 64;
  localparam int SAMPLE_DEPTH_DEF = 64;

  localparam int HIT_W  = 32;
  localparam int TOT_W  = 48;
  localparam int IN_W   = 96;
  localparam int OUT_W  = 136;

  typedef enum logic [2:0] {
    CMD_ENTER   = 3'd0,
    CMD_EXIT    = 3'd1,
    CMD_TAIL    = 3'd2,
    CMD_SAMPLE  = 3'd3,
    CMD_RD_BLK  = 3'd4,
    CMD_RD_EDGE = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2
  } sts_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOAD,
    OP_DISP,
    OP_ENT_SLOT,
    OP_ENT_UPD,
    OP_EXIT_LD,
    OP_SMP_RR,
    OP_SMP_ER,
    OP_SMP_WR,
    OP_ROOT_WR,
    OP_RD_DATA,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       blk_ok;
    logic       top_zero;
    logic       smp_done;
    logic       clr_last;
  } dp_sts_t;

  function automatic logic [HIT_W-1:0] inc_sat32(input logic [HIT_W-1:0] v);
    return (&v) ? v : v + HIT_W'(1);
  endfunction

  function automatic logic [TOT_W-1:0] add_sat48(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

endpackage

/* design/cgpa_ram.sv */
module cgpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/cgpa_ctrl.sv */
`include "call_graph_profile_accumulator_defines.svh"

module cgpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  output logic               in_rdy_o,
  output logic               out_vld_o,
  input  logic               out_rdy_i,
  input  cgpa_pkg::dp_sts_t  sts_i,
  output cgpa_pkg::ctrl_cmd_t cmd_o
);
  import cgpa_pkg::*;

  typedef enum logic [12:0] {
    ST_CLEAR    = 13'b0000000000001,
    ST_IDLE     = 13'b0000000000010,
    ST_DISP     = 13'b0000000000100,
    ST_ENT_SLOT = 13'b0000000001000,
    ST_ENT_UPD  = 13'b0000000010000,
    ST_EXIT_LD  = 13'b0000000100000,
    ST_SMP_RR   = 13'b0000001000000,
    ST_SMP_ER   = 13'b0000010000000,
    ST_SMP_WR   = 13'b0000100000000,
    ST_ROOT_WR  = 13'b0001000000000,
    ST_RD_DATA  = 13'b0010000000000,
    ST_FIN      = 13'b0100000000000,
    ST_SPARE    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.op       = OP_IDLE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_vld_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISP;
        end
      end
      ST_DISP: begin
        cmd_o.op = OP_DISP;
        unique case (sts_i.cmd) inside
          CMD_ENTER:              state_d = sts_i.blk_ok ? ST_ENT_SLOT : ST_FIN;
          CMD_EXIT:               state_d = sts_i.top_zero ? ST_FIN : ST_EXIT_LD;
          CMD_SAMPLE:             state_d = ST_SMP_RR;
          CMD_RD_BLK, CMD_RD_EDGE: state_d = ST_RD_DATA;
          default:                state_d = ST_FIN;
        endcase
      end
      ST_ENT_SLOT: begin
        cmd_o.op = OP_ENT_SLOT;
        state_d  = ST_ENT_UPD;
      end
      ST_ENT_UPD: begin
        cmd_o.op = OP_ENT_UPD;
        state_d  = ST_FIN;
      end
      ST_EXIT_LD: begin
        cmd_o.op = OP_EXIT_LD;
        state_d  = ST_FIN;
      end
      ST_SMP_RR: begin
        cmd_o.op = OP_SMP_RR;
        state_d  = sts_i.smp_done ? ST_ROOT_WR : ST_SMP_ER;
      end
      ST_SMP_ER: begin
        cmd_o.op = OP_SMP_ER;
        state_d  = ST_SMP_WR;
      end
      ST_SMP_WR: begin
        cmd_o.op = OP_SMP_WR;
        state_d  = ST_SMP_RR;
      end
      ST_ROOT_WR: begin
        cmd_o.op = OP_ROOT_WR;
        state_d  = ST_FIN;
      end
      ST_RD_DATA: begin
        cmd_o.op = OP_RD_DATA;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        if (!out_vld_q || out_rdy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_rdy_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_rdy_o  = (state_q == ST_IDLE);
  assign out_vld_o = out_vld_q;

  `CGPA_ASSERT(out_from_fin_a, $rose(out_vld_q) |-> $past(state_q == ST_FIN), "result without finish")
  `CGPA_ASSERT_NEXT(accept_disp_a, in_vld_i && in_rdy_o, state_q == ST_DISP, "accept not dispatched")
  `CGPA_ASSERT(no_accept_clear_a, state_q == ST_CLEAR |-> !in_rdy_o, "accept during clear")

endmodule

/* design/cgpa_dp.sv */
`include "call_graph_profile_accumulator_defines.svh"

module cgpa_dp #(
  parameter int NUM_BLOCKS   = cgpa_pkg::NUM_BLOCKS_DEF,
  parameter int CALL_DEPTH   = cgpa_pkg::CALL_DEPTH_DEF,
  parameter int SAMPLE_DEPTH = cgpa_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cgpa_pkg::ctrl_cmd_t        cmd_i,
  output cgpa_pkg::dp_sts_t          sts_o,
  input  logic [cgpa_pkg::IN_W-1:0]  in_data_i,
  output logic [cgpa_pkg::OUT_W-1:0] out_data_o
);
  import cgpa_pkg::*;

  localparam int BW   = $clog2(NUM_BLOCKS);
  localparam int EW   = 2 * BW;
  localparam int ED   = 1 << EW;
  localparam int FW   = $clog2(CALL_DEPTH);
  localparam int SW   = $clog2(SAMPLE_DEPTH);
  localparam int CW   = $clog2(SAMPLE_DEPTH + 1);
  localparam int ST_W = HIT_W + 2 * TOT_W;
  localparam int ER_W = 1 + SW + ST_W;
  localparam int FR_W = BW + CW;

  logic [2:0]       cmd_q;
  logic [3:0]       blk_q, cal_q;
  logic [HIT_W-1:0] stime_q;
  logic [TOT_W-1:0] now_q;

  logic [FW-1:0]    top_q, top_d;
  logic [BW-1:0]    top_blk_q, top_blk_d;
  logic [CW-1:0]    top_exit_q, top_exit_d;
  logic [CW-1:0]    count_q, count_d;
  logic             tail_q, tail_d;
  logic [TOT_W-1:0] last_q, last_d;
  logic [EW-1:0]    clr_q, clr_d;

  logic [ER_W-1:0]       edge_rec_q, edge_rec_d;
  logic [ST_W-1:0]       blk_rec_q, blk_rec_d;
  logic [EW-1:0]         e_q, e_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [TOT_W-1:0]      delta_q, delta_d;
  logic [NUM_BLOCKS-1:0] seen_q, seen_d;
  logic [1:0]            pend_sts_q, pend_sts_d;
  logic [HIT_W-1:0]      pend_hits_q, pend_hits_d;
  logic [TOT_W-1:0]      pend_wall_q, pend_wall_d;
  logic [TOT_W-1:0]      pend_time_q, pend_time_d;
  logic [OUT_W-1:0]      out_q;

  logic            er_we;
  logic [EW-1:0]   er_waddr, er_raddr;
  logic [ER_W-1:0] er_wdata, er_rdata;
  logic            br_we;
  logic [BW-1:0]   br_waddr, br_raddr;
  logic [ST_W-1:0] br_wdata, br_rdata;
  logic            fr_we;
  logic [FW-1:0]   fr_waddr, fr_raddr;
  logic [FR_W-1:0] fr_wdata, fr_rdata;
  logic            rr_we;
  logic [SW-1:0]   rr_waddr, rr_raddr;
  logic [EW-1:0]   rr_wdata, rr_rdata;

  logic [BW-1:0]  blk_idx, cal_idx, smp_blk;
  logic [EW-1:0]  ent_e;
  logic           blk_ok, cal_ok;
  logic [SW-1:0]  ent_slot;
  logic           ent_vld, running, ent_fail;
  logic [CW-1:0]  exit_base;
  logic [TOT_W-1:0] stime_ext;
  logic           exit_pop;

  assign blk_idx   = BW'(blk_q);
  assign cal_idx   = BW'(cal_q);
  assign blk_ok    = ({28'd0, blk_q} < 32'(NUM_BLOCKS));
  assign cal_ok    = ({28'd0, cal_q} < 32'(NUM_BLOCKS));
  assign ent_e     = {top_blk_q, blk_idx};
  assign ent_slot  = edge_rec_q[ST_W +: SW];
  assign ent_vld   = edge_rec_q[ER_W-1];
  assign running   = ent_vld && (CW'(ent_slot) < count_q) && (rr_rdata == ent_e);
  assign ent_fail  = (!tail_q && (top_q == FW'(CALL_DEPTH - 1))) ||
                     (!running && (count_q == CW'(SAMPLE_DEPTH)));
  assign exit_base = tail_q ? top_exit_q : '0;
  assign smp_blk   = e_q[BW-1:0];
  assign stime_ext = TOT_W'(stime_q);
  assign exit_pop  = (cmd_i.op == OP_DISP) && (cmd_q == CMD_EXIT) && (top_q != '0);

  always_comb begin
    top_d       = top_q;
    top_blk_d   = top_blk_q;
    top_exit_d  = top_exit_q;
    count_d     = count_q;
    tail_d      = tail_q;
    last_d      = last_q;
    clr_d       = clr_q;
    edge_rec_d  = edge_rec_q;
    blk_rec_d   = blk_rec_q;
    e_d         = e_q;
    idx_d       = idx_q;
    delta_d     = delta_q;
    seen_d      = seen_q;
    pend_sts_d  = pend_sts_q;
    pend_hits_d = pend_hits_q;
    pend_wall_d = pend_wall_q;
    pend_time_d = pend_time_q;
    er_we = 1'b0; er_waddr = ent_e; er_wdata = '0; er_raddr = ent_e;
    br_we = 1'b0; br_waddr = blk_idx; br_wdata = '0; br_raddr = blk_idx;
    fr_we = 1'b0; fr_waddr = top_q; fr_wdata = {top_blk_q, top_exit_q};
    fr_raddr = top_q - FW'(1);
    rr_we = 1'b0; rr_waddr = count_q[SW-1:0]; rr_wdata = ent_e;
    rr_raddr = ent_slot;

    case (cmd_i.op)
      OP_CLEAR: begin
        er_we    = 1'b1;
        er_waddr = clr_q;
        if ({{(32-EW){1'b0}}, clr_q} < 32'(NUM_BLOCKS)) begin
          br_we    = 1'b1;
          br_waddr = clr_q[BW-1:0];
          br_wdata = {((clr_q == '0) ? HIT_W'(1) : HIT_W'(0)), {(2*TOT_W){1'b0}}};
        end
        clr_d = clr_q + EW'(1);
      end
      OP_DISP: begin
        pend_sts_d  = STS_OK;
        pend_hits_d = '0;
        pend_wall_d = '0;
        pend_time_d = '0;
        unique case (cmd_q) inside
          CMD_EXIT: begin
            if (top_q == '0) begin
              pend_sts_d = STS_UNDERFLOW;
            end else begin
              count_d = (top_exit_q > count_q) ? '0 : count_q - top_exit_q;
              top_d   = top_q - FW'(1);
            end
          end
          CMD_TAIL: begin
            tail_d = 1'b1;
          end
          CMD_SAMPLE: begin
            delta_d = (last_q == '0) ? '0 : now_q - last_q;
            last_d  = now_q;
            seen_d  = '0;
            idx_d   = '0;
          end
          CMD_RD_EDGE: begin
            er_raddr = {cal_idx, blk_idx};
          end
          default: begin
          end
        endcase
      end
      OP_ENT_SLOT: begin
        edge_rec_d = er_rdata;
        blk_rec_d  = br_rdata;
        rr_raddr   = er_rdata[ST_W +: SW];
      end
      OP_ENT_UPD: begin
        if (ent_fail) begin
          pend_sts_d = STS_OVERFLOW;
        end else begin
          br_we    = 1'b1;
          br_wdata = {inc_sat32(blk_rec_q[2*TOT_W +: HIT_W]), blk_rec_q[2*TOT_W-1:0]};
          er_we    = 1'b1;
          er_wdata = {1'b1, (running ? ent_slot : count_q[SW-1:0]),
                      inc_sat32(edge_rec_q[2*TOT_W +: HIT_W]), edge_rec_q[2*TOT_W-1:0]};
          if (!tail_q) begin
            fr_we = 1'b1;
            top_d = top_q + FW'(1);
          end
          top_blk_d = blk_idx;
          tail_d    = 1'b0;
          if (!running) begin
            rr_we      = 1'b1;
            count_d    = count_q + CW'(1);
            top_exit_d = exit_base + CW'(1);
          end else begin
            top_exit_d = exit_base;
          end
        end
      end
      OP_EXIT_LD: begin
        top_blk_d  = fr_rdata[CW +: BW];
        top_exit_d = fr_rdata[CW-1:0];
      end
      OP_SMP_RR: begin
        rr_raddr = idx_q[SW-1:0];
        br_raddr = '0;
      end
      OP_SMP_ER: begin
        e_d      = rr_rdata;
        er_raddr = rr_rdata;
        br_raddr = rr_rdata[BW-1:0];
      end
      OP_SMP_WR: begin
        er_we    = 1'b1;
        er_waddr = e_q;
        er_wdata = {er_rdata[ER_W-1 -: 1+SW+HIT_W],
                    add_sat48(er_rdata[TOT_W +: TOT_W], delta_q),
                    add_sat48(er_rdata[TOT_W-1:0], stime_ext)};
        if (!seen_q[smp_blk]) begin
          seen_d[smp_blk] = 1'b1;
          br_we    = 1'b1;
          br_waddr = smp_blk;
          br_wdata = {br_rdata[2*TOT_W +: HIT_W],
                      add_sat48(br_rdata[TOT_W +: TOT_W], delta_q),
                      add_sat48(br_rdata[TOT_W-1:0], stime_ext)};
        end
        idx_d = idx_q + CW'(1);
      end
      OP_ROOT_WR: begin
        br_we    = 1'b1;
        br_waddr = '0;
        br_wdata = {br_rdata[2*TOT_W +: HIT_W],
                    add_sat48(br_rdata[TOT_W +: TOT_W], delta_q),
                    add_sat48(br_rdata[TOT_W-1:0], stime_ext)};
      end
      OP_RD_DATA: begin
        if (cmd_q == CMD_RD_BLK && blk_ok) begin
          pend_hits_d = br_rdata[2*TOT_W +: HIT_W];
          pend_wall_d = br_rdata[TOT_W +: TOT_W];
          pend_time_d = br_rdata[TOT_W-1:0];
        end else if (cmd_q == CMD_RD_EDGE && blk_ok && cal_ok) begin
          pend_hits_d = er_rdata[2*TOT_W +: HIT_W];
          pend_wall_d = er_rdata[TOT_W +: TOT_W];
          pend_time_d = er_rdata[TOT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= '0;
      top_blk_q  <= '0;
      top_exit_q <= '0;
      count_q    <= '0;
      tail_q     <= 1'b0;
      last_q     <= '0;
      clr_q      <= '0;
    end else begin
      top_q      <= top_d;
      top_blk_q  <= top_blk_d;
      top_exit_q <= top_exit_d;
      count_q    <= count_d;
      tail_q     <= tail_d;
      last_q     <= last_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      cmd_q   <= in_data_i[2:0];
      blk_q   <= in_data_i[6:3];
      cal_q   <= in_data_i[10:7];
      stime_q <= in_data_i[42:11];
      now_q   <= in_data_i[90:43];
    end
    if (cmd_i.out_load) begin
      out_q <= {6'd0, pend_time_q, pend_wall_q, pend_hits_q, pend_sts_q};
    end
    edge_rec_q  <= edge_rec_d;
    blk_rec_q   <= blk_rec_d;
    e_q         <= e_d;
    idx_q       <= idx_d;
    delta_q     <= delta_d;
    seen_q      <= seen_d;
    pend_sts_q  <= pend_sts_d;
    pend_hits_q <= pend_hits_d;
    pend_wall_q <= pend_wall_d;
    pend_time_q <= pend_time_d;
  end

  cgpa_ram #(.WIDTH(ER_W), .DEPTH(ED)) u_edge_ram (
    .clk_i, .we_i(er_we), .waddr_i(er_waddr), .wdata_i(er_wdata),
    .raddr_i(er_raddr), .rdata_o(er_rdata)
  );

  cgpa_ram #(.WIDTH(ST_W), .DEPTH(NUM_BLOCKS)) u_block_ram (
    .clk_i, .we_i(br_we), .waddr_i(br_waddr), .wdata_i(br_wdata),
    .raddr_i(br_raddr), .rdata_o(br_rdata)
  );

  cgpa_ram #(.WIDTH(FR_W), .DEPTH(CALL_DEPTH)) u_frame_ram (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );

  cgpa_ram #(.WIDTH(EW), .DEPTH(SAMPLE_DEPTH)) u_run_ram (
    .clk_i, .we_i(rr_we), .waddr_i(rr_waddr), .wdata_i(rr_wdata),
    .raddr_i(rr_raddr), .rdata_o(rr_rdata)
  );

  assign sts_o.cmd      = cmd_q;
  assign sts_o.blk_ok   = blk_ok;
  assign sts_o.top_zero = (top_q == '0);
  assign sts_o.smp_done = (idx_q == count_q);
  assign sts_o.clr_last = (clr_q == {EW{1'b1}});
  assign out_data_o     = out_q;

  `CGPA_ASSERT(count_bound_a, count_q <= CW'(SAMPLE_DEPTH), "running count past depth")
  `CGPA_ASSERT_NEXT(exit_pop_a, exit_pop, top_q == $past(top_q) - FW'(1), "exit did not pop")
  `CGPA_ASSERT_NEXT(tail_set_a, cmd_i.op == OP_DISP && cmd_q == CMD_TAIL, tail_q, "tail mark lost")

endmodule

/* design/call_graph_profile_accumulator.sv */
// Each item is loaded, dispatched and finished; an enter with a valid block id adds a slot lookup and
// an update, an exit below the root a frame load, a read a data fetch;
// a sample walks its running edges (one edge-RAM read-modify-write each), then updates the root block.
// One item is in work at a time; the next is taken once the result is in the output register.
// Reset is asynchronous, active low; afterwards a clearing pass zeroes the edge and block statistics
// memories (root block 0 starts with a hit count of one) before any item is taken.
module call_graph_profile_accumulator #(
  parameter int NUM_BLOCKS   = cgpa_pkg::NUM_BLOCKS_DEF,
  parameter int CALL_DEPTH   = cgpa_pkg::CALL_DEPTH_DEF,
  parameter int SAMPLE_DEPTH = cgpa_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // cmd[2:0], block_id[6:3], caller_id[10:7], sample_time[42:11], now_ms[90:43]
  input  logic [cgpa_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status[1:0], hit_count[33:2], wall_total[81:34], time_total[129:82]
  output logic [cgpa_pkg::OUT_W-1:0] m_axis_tdata
);
  import cgpa_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  cgpa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_vld_i  (s_axis_tvalid),
    .in_rdy_o  (s_axis_tready),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cgpa_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .CALL_DEPTH  (CALL_DEPTH),
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import cgpa_pkg::*;

  localparam int NB = 16;
  localparam int CD = 64;
  localparam int SD = 64;
  localparam logic [31:0] HMAX = 32'hFFFF_FFFF;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int LIMIT = 2_000_000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hits;
    logic [47:0] wall;
    logic [47:0] tot;
  } prof_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  call_graph_profile_accumulator dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [3:0]  fr_blk [CD];
  logic [6:0]  fr_exits [CD];
  int          fr_top;
  logic [7:0]  run_edge [SD];
  int          run_cnt;
  logic        e_valid [NB*NB];
  int          e_slot [NB*NB];
  logic [31:0] e_hits [NB*NB];
  logic [47:0] e_wall [NB*NB];
  logic [47:0] e_time [NB*NB];
  logic [31:0] b_hits [NB];
  logic [47:0] b_wall [NB];
  logic [47:0] b_time [NB];
  logic        tail_pend;
  logic [47:0] prev_wall;

  prof_res_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  longint cycles = 0;
  int hold_off = 0;
  int gap_left = 0;

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TMAX : s[47:0];
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == HMAX) ? v : v + 1;
  endfunction

  function automatic void profile_reset();
    for (int i = 0; i < CD; i++) begin
      fr_blk[i] = '0;
      fr_exits[i] = '0;
    end
    for (int i = 0; i < NB*NB; i++) begin
      e_valid[i] = 0; e_slot[i] = 0; e_hits[i] = 0; e_wall[i] = 0; e_time[i] = 0;
    end
    for (int i = 0; i < NB; i++) begin
      b_hits[i] = 0; b_wall[i] = 0; b_time[i] = 0;
    end
    for (int i = 0; i < SD; i++) run_edge[i] = '0;
    b_hits[0] = 1;
    fr_top = 0; run_cnt = 0; tail_pend = 0; prev_wall = 0;
  endfunction

  function automatic prof_res_t profile_step(logic [IN_W-1:0] d);
    prof_res_t r;
    logic [2:0] cmd;
    logic [3:0] blk, cal;
    logic [31:0] t;
    logic [47:0] now, dw;
    int e, c, n;
    bit running;
    bit seen [NB];
    r = '0;
    cmd = d[2:0]; blk = d[6:3]; cal = d[10:7]; t = d[42:11]; now = d[90:43];
    case (cmd)
      CMD_ENTER: begin
        e = fr_blk[fr_top] * NB + blk;
        running = e_valid[e] && e_slot[e] < run_cnt && run_edge[e_slot[e]] == e;
        if (!tail_pend && fr_top + 1 >= CD) r.status = STS_OVERFLOW;
        else if (!running && run_cnt >= SD) r.status = STS_OVERFLOW;
        else begin
          b_hits[blk] = sat_inc(b_hits[blk]);
          if (!e_valid[e]) begin
            e_valid[e] = 1;
            e_slot[e] = run_cnt;
          end
          e_hits[e] = sat_inc(e_hits[e]);
          if (!tail_pend) begin
            fr_top++;
            fr_exits[fr_top] = 0;
          end
          fr_blk[fr_top] = blk;
          tail_pend = 0;
          if (!running) begin
            e_slot[e] = run_cnt;
            run_edge[run_cnt] = e;
            run_cnt++;
            fr_exits[fr_top]++;
          end
        end
      end
      CMD_EXIT: begin
        if (fr_top == 0) r.status = STS_UNDERFLOW;
        else begin
          n = fr_exits[fr_top];
          run_cnt = (n > run_cnt) ? 0 : run_cnt - n;
          fr_top--;
        end
      end
      CMD_TAIL: tail_pend = 1;
      CMD_SAMPLE: begin
        if (prev_wall == 0) prev_wall = now;
        dw = now - prev_wall;
        prev_wall = now;
        foreach (seen[i]) seen[i] = 0;
        for (int i = 0; i < run_cnt; i++) begin
          e = run_edge[i];
          c = e % NB;
          if (!seen[c]) begin
            seen[c] = 1;
            b_wall[c] = sat_add(b_wall[c], dw);
            b_time[c] = sat_add(b_time[c], {16'd0, t});
          end
          e_wall[e] = sat_add(e_wall[e], dw);
          e_time[e] = sat_add(e_time[e], {16'd0, t});
        end
        b_wall[0] = sat_add(b_wall[0], dw);
        b_time[0] = sat_add(b_time[0], {16'd0, t});
      end
      CMD_RD_BLK: begin
        r.hits = b_hits[blk]; r.wall = b_wall[blk]; r.tot = b_time[blk];
      end
      CMD_RD_EDGE: begin
        e = cal * NB + blk;
        r.hits = e_hits[e]; r.wall = e_wall[e]; r.tot = e_time[e];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_cmd(logic [2:0] cmd, logic [3:0] blk,
                                               logic [3:0] cal, logic [31:0] t,
                                               logic [47:0] now);
    logic [IN_W-1:0] d;
    d = '0;
    d[2:0] = cmd; d[6:3] = blk; d[10:7] = cal; d[42:11] = t; d[90:43] = now;
    return d;
  endfunction

  task automatic report(string what, prof_res_t got, prof_res_t exp);
    $display("mismatch %s: got %h exp %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  task automatic send_item(logic [IN_W-1:0] d);
    if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      gap_left = $urandom_range(1, 12);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(profile_step(d));
    n_items++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    prof_res_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.hits   = m_axis_tdata[33:2];
      got.wall   = m_axis_tdata[81:34];
      got.tot    = m_axis_tdata[129:82];
      n_results++;
      if (expected_q.size() == 0) report("unexpected result", got, '0);
      else begin
        exp = expected_q.pop_front();
        if (got.status !== exp.status) report("status", got, exp);
        if (got.hits !== exp.hits) report("hit_count", got, exp);
        if (got.wall !== exp.wall) report("wall_total", got, exp);
        if (got.tot !== exp.tot) report("time_total", got, exp);
      end
    end
  end

  task automatic test_directed();
    send_item(pack_cmd(CMD_EXIT, 0, 0, 0, 0));
    send_item(pack_cmd(CMD_RD_BLK, 0, 0, 0, 0));
    send_item(pack_cmd(CMD_SAMPLE, 0, 0, 32'd5, 48'd100));
    send_item(pack_cmd(CMD_ENTER, 4'd15, 0, 0, 0));
    send_item(pack_cmd(CMD_ENTER, 4'd3, 0, 0, 0));
    send_item(pack_cmd(CMD_ENTER, 4'd15, 0, 0, 0));
    send_item(pack_cmd(CMD_SAMPLE, 0, 0, HMAX, 48'd50));
    send_item(pack_cmd(CMD_SAMPLE, 0, 0, HMAX, TMAX));
    send_item(pack_cmd(CMD_SAMPLE, 0, 0, HMAX, 48'd1));
    send_item(pack_cmd(CMD_TAIL, 0, 0, 0, 0));
    send_item(pack_cmd(CMD_ENTER, 4'd7, 0, 0, 0));
    send_item(pack_cmd(CMD_RD_EDGE, 4'd15, 4'd3, 0, 0));
    send_item(pack_cmd(CMD_RD_EDGE, 4'd3, 4'd15, 0, 0));
    send_item(pack_cmd(CMD_RD_BLK, 4'd15, 0, 0, 0));
    send_item(pack_cmd(3'd6, 4'd15, 4'd15, HMAX, TMAX));
    send_item(pack_cmd(3'd7, 0, 0, 0, 0));
    repeat (4) send_item(pack_cmd(CMD_EXIT, 0, 0, 0, 0));
    send_item(pack_cmd(CMD_RD_BLK, 0, 0, 0, 0));
  endtask

  task automatic test_call_overflow();
    for (int i = 0; i < CD + 2; i++)
      send_item(pack_cmd(CMD_ENTER, 4'($urandom_range(0, 15)), 0, 0, 0));
    send_item(pack_cmd(CMD_TAIL, 0, 0, 0, 0));
    send_item(pack_cmd(CMD_ENTER, 4'd9, 0, 0, 0));
    send_item(pack_cmd(CMD_SAMPLE, 0, 0, 32'd7, 48'd1000));
    for (int i = 0; i < CD + 2; i++) send_item(pack_cmd(CMD_EXIT, 0, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 20; i++)
      send_item(pack_cmd(CMD_RD_BLK, 4'($urandom_range(0, 15)), 0, 0, 0));
  endtask

  task automatic test_random(int count);
    logic [47:0] clk_ms;
    logic [2:0] cmd;
    logic [47:0] now;
    logic [31:0] t;
    clk_ms = 48'd1;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: cmd = CMD_ENTER;
        6, 7, 8, 9: cmd = CMD_EXIT;
        10: cmd = CMD_TAIL;
        11, 12: cmd = CMD_SAMPLE;
        13, 14, 15: cmd = CMD_RD_BLK;
        16, 17, 18: cmd = CMD_RD_EDGE;
        default: cmd = 3'($urandom_range(6, 7));
      endcase
      case ($urandom_range(0, 9))
        0: now = 48'({$urandom, $urandom});
        1: now = 48'd0;
        default: begin
          clk_ms = clk_ms + $urandom_range(0, 5000);
          now = clk_ms;
        end
      endcase
      t = $urandom_range(0, 1000);
      if ($urandom_range(0, 1) == 1) t = t | $urandom;
      if ($urandom_range(0, 9) == 0) t = HMAX;
      send_item(pack_cmd(cmd, 4'($urandom), 4'($urandom), t, now));
    end
  endtask

  task automatic test_readout();
    for (int b = 0; b < NB; b++) send_item(pack_cmd(CMD_RD_BLK, 4'(b), 0, 0, 0));
    for (int i = 0; i < 32; i++)
      send_item(pack_cmd(CMD_RD_EDGE, 4'($urandom), 4'($urandom), 0, 0));
  endtask

  initial begin
    profile_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_call_overflow();
    test_backpressure();
    test_random(1150);
    test_readout();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("covered %0d items, %0d results: call stack limits, tail calls, samples,",
             n_items, n_results);
    $display("saturation, reads, unknown codes and a long output stall");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
